// ----- rtl/core/tsepoch_pkg.sv -----
// ----------------------------------------------------------------------------
// tsepoch_pkg
// Shared types, constants and tables for the timestamp text to epoch block.
// ----------------------------------------------------------------------------
package tsepoch_pkg;

    // character positions of the fixed layout
    localparam logic [4:0] PosYearEnd  = 5'd3;
    localparam logic [4:0] PosDash1    = 5'd4;
    localparam logic [4:0] PosMonthEnd = 5'd6;
    localparam logic [4:0] PosDash2    = 5'd7;
    localparam logic [4:0] PosDayEnd   = 5'd9;
    localparam logic [4:0] PosSep      = 5'd10;
    localparam logic [4:0] PosHourEnd  = 5'd12;
    localparam logic [4:0] PosColon1   = 5'd13;
    localparam logic [4:0] PosMinEnd   = 5'd15;
    localparam logic [4:0] PosColon2   = 5'd16;
    localparam logic [4:0] PosSecEnd   = 5'd18;
    localparam logic [4:0] PosFrac     = 5'd19;
    localparam logic [4:0] PosFracEnd  = 5'd25;
    localparam logic [4:0] PosMax      = 5'd31;

    localparam logic [2:0] FracDigits  = 3'd6;

    // shared multiplier constants
    localparam logic [12:0] KDiv100 = 13'd5243;   // floor(x / 100) = (x * KDiv100) >> 19
    localparam logic [12:0] KYear   = 13'd365;
    localparam logic [12:0] KHours  = 13'd24;
    localparam logic [12:0] KSixty  = 13'd60;
    localparam logic [12:0] KMilli  = 13'd1000;
    localparam logic [12:0] KTen    = 13'd10;
    localparam logic [12:0] KNone   = 13'd0;

    localparam logic [13:0] YearBias = 14'd400;
    localparam logic signed [21:0] DayBias = 22'sd865566;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [19:0] fraction;
        logic [2:0]  frac_cnt;
        logic        fmt_ok;
    } t_fields;

    typedef enum logic [3:0] {
        CV_IDLE,
        CV_FRAC,
        CV_DIV,
        CV_DAYS,
        CV_HOUR,
        CV_MIN,
        CV_SEC,
        CV_MS,
        CV_US,
        CV_DONE
    } t_conv_state;

    // days from March 1 to the first of the month
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] v;
        case (month)
            4'd1:    v = 9'd306;
            4'd2:    v = 9'd337;
            4'd3:    v = 9'd0;
            4'd4:    v = 9'd31;
            4'd5:    v = 9'd61;
            4'd6:    v = 9'd92;
            4'd7:    v = 9'd122;
            4'd8:    v = 9'd153;
            4'd9:    v = 9'd184;
            4'd10:   v = 9'd214;
            4'd11:   v = 9'd245;
            4'd12:   v = 9'd275;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/tsepoch_parser.sv -----
// ----------------------------------------------------------------------------
// tsepoch_parser
// Character scanner: tracks position, accumulates fields, flags format errors.
// ----------------------------------------------------------------------------
module tsepoch_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [7:0]              i_text_char,
    input  logic                    i_last_char,
    output tsepoch_pkg::t_fields    o_fields
);

    localparam logic [7:0] ChDash  = 8'h2D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChT     = 8'h54;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChDot   = 8'h2E;

    logic [4:0]  r_pos, n_pos;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic [19:0] r_frac, n_frac;
    logic [2:0]  r_fcnt, n_fcnt;
    logic        r_fmt_err, n_fmt_err;
    logic        r_fstop, n_fstop;

    logic       dig;
    logic [3:0] d;

    assign dig = (i_text_char inside {[8'h30:8'h39]});
    assign d   = dig ? i_text_char[3:0] : 4'd0;

    always_comb begin
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_second  = r_second;
        n_frac    = r_frac;
        n_fcnt    = r_fcnt;
        n_fmt_err = r_fmt_err;
        n_fstop   = r_fstop;
        n_pos     = (r_pos < tsepoch_pkg::PosMax) ? r_pos + 5'd1 : r_pos;

        if (r_pos <= tsepoch_pkg::PosSecEnd) begin
            if (r_pos == tsepoch_pkg::PosDash1 || r_pos == tsepoch_pkg::PosDash2) begin
                if (i_text_char != ChDash) n_fmt_err = 1'b1;
            end else if (r_pos == tsepoch_pkg::PosSep) begin
                if (i_text_char != ChSpace && i_text_char != ChT) n_fmt_err = 1'b1;
            end else if (r_pos == tsepoch_pkg::PosColon1
                         || r_pos == tsepoch_pkg::PosColon2) begin
                if (i_text_char != ChColon) n_fmt_err = 1'b1;
            end else if (!dig) begin
                n_fmt_err = 1'b1;
            end else if (r_pos <= tsepoch_pkg::PosYearEnd) begin
                n_year = 14'(r_year * 14'd10 + {10'd0, d});
            end else if (r_pos <= tsepoch_pkg::PosMonthEnd) begin
                n_month = 7'(r_month * 7'd10 + {3'd0, d});
            end else if (r_pos <= tsepoch_pkg::PosDayEnd) begin
                n_day = 7'(r_day * 7'd10 + {3'd0, d});
            end else if (r_pos <= tsepoch_pkg::PosHourEnd) begin
                n_hour = 7'(r_hour * 7'd10 + {3'd0, d});
            end else if (r_pos <= tsepoch_pkg::PosMinEnd) begin
                n_minute = 7'(r_minute * 7'd10 + {3'd0, d});
            end else begin
                n_second = 7'(r_second * 7'd10 + {3'd0, d});
            end
        end else if (r_pos == tsepoch_pkg::PosFrac) begin
            if (i_text_char != ChDot) n_fstop = 1'b1;
        end else if (r_pos <= tsepoch_pkg::PosFracEnd) begin
            if (!r_fstop && dig && r_fcnt < tsepoch_pkg::FracDigits) begin
                n_frac = 20'(r_frac * 20'd10 + {16'd0, d});
                n_fcnt = r_fcnt + 3'd1;
            end else begin
                n_fstop = 1'b1;
            end
        end
    end

    always_comb begin
        o_fields.year     = n_year;
        o_fields.month    = n_month;
        o_fields.day      = n_day;
        o_fields.hour     = n_hour;
        o_fields.minute   = n_minute;
        o_fields.second   = n_second;
        o_fields.fraction = n_frac;
        o_fields.frac_cnt = n_fcnt;
        o_fields.fmt_ok   = (r_pos >= tsepoch_pkg::PosSecEnd) && !n_fmt_err
                            && (n_month inside {[7'd1:7'd12]})
                            && (n_day inside {[7'd1:7'd31]})
                            && (n_hour <= 7'd23) && (n_minute <= 7'd59)
                            && (n_second <= 7'd61);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_char)) begin
            r_pos     <= '0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_second  <= '0;
            r_frac    <= '0;
            r_fcnt    <= '0;
            r_fmt_err <= 1'b0;
            r_fstop   <= 1'b0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_year    <= n_year;
            r_month   <= n_month;
            r_day     <= n_day;
            r_hour    <= n_hour;
            r_minute  <= n_minute;
            r_second  <= n_second;
            r_frac    <= n_frac;
            r_fcnt    <= n_fcnt;
            r_fmt_err <= n_fmt_err;
            r_fstop   <= n_fstop;
        end
    end

endmodule

// ----- rtl/core/tsepoch_mac.sv -----
// ----------------------------------------------------------------------------
// tsepoch_mac
// Shared multiply-add unit: p = a * k + c, truncated to the accumulator width.
// ----------------------------------------------------------------------------
module tsepoch_mac (
    input  logic signed [59:0] i_a,
    input  logic        [12:0] i_k,
    input  logic signed [59:0] i_c,
    output logic signed [59:0] o_p
);

    logic signed [73:0] prod;

    assign prod = i_a * $signed({1'b0, i_k});
    assign o_p  = $signed(prod[59:0]) + i_c;

endmodule

// ----- rtl/core/tsepoch_conv.sv -----
// ----------------------------------------------------------------------------
// tsepoch_conv
// Sequencer that turns captured fields into epoch microseconds on the
// shared multiply-add unit, and the output register.
// ----------------------------------------------------------------------------
module tsepoch_conv (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  tsepoch_pkg::t_fields    i_fields,
    output logic                    o_busy,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [58:0]      o_epoch_micros,
    output logic                    o_parsed_ok
);

    tsepoch_pkg::t_conv_state r_state, n_state;
    tsepoch_pkg::t_fields     r_f;

    logic signed [59:0] r_acc, n_acc;
    logic [2:0]         r_fcnt, n_fcnt;
    logic [19:0]        r_frac_us, n_frac_us;
    logic [6:0]         r_q100, n_q100;
    logic signed [21:0] r_base, n_base;
    logic               r_neg1, n_neg1;
    logic               r_ok, n_ok;
    logic               r_out_valid, n_out_valid;
    logic signed [58:0] r_epoch, n_epoch;
    logic               r_pok, n_pok;

    logic [13:0]        y_adj;
    logic signed [59:0] mac_a, mac_c, mac_p;
    logic [12:0]        mac_k;

    assign y_adj = r_f.year + tsepoch_pkg::YearBias - 14'(r_f.month <= 7'd2);

    tsepoch_mac u_mac (
        .i_a (mac_a),
        .i_k (mac_k),
        .i_c (mac_c),
        .o_p (mac_p)
    );

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_fcnt      = r_fcnt;
        n_frac_us   = r_frac_us;
        n_q100      = r_q100;
        n_base      = r_base;
        n_neg1      = r_neg1;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_epoch     = r_epoch;
        n_pok       = r_pok;
        mac_a       = r_acc;
        mac_k       = tsepoch_pkg::KNone;
        mac_c       = '0;

        case (r_state)
            tsepoch_pkg::CV_IDLE: begin
                if (i_start) begin
                    n_acc   = $signed({40'd0, i_fields.fraction});
                    n_fcnt  = i_fields.frac_cnt;
                    n_ok    = i_fields.fmt_ok;
                    n_neg1  = 1'b0;
                    n_state = tsepoch_pkg::CV_FRAC;
                end
            end
            tsepoch_pkg::CV_FRAC: begin
                if (r_fcnt >= tsepoch_pkg::FracDigits) begin
                    n_state = tsepoch_pkg::CV_DIV;
                end else begin
                    mac_k  = tsepoch_pkg::KTen;
                    n_acc  = mac_p;
                    n_fcnt = r_fcnt + 3'd1;
                end
            end
            tsepoch_pkg::CV_DIV: begin
                mac_a     = $signed({46'd0, y_adj});
                mac_k     = tsepoch_pkg::KDiv100;
                n_q100    = mac_p[25:19];
                n_frac_us = r_acc[19:0];
                n_base    = $signed({10'd0, y_adj[13:2]})
                            + $signed({13'd0, tsepoch_pkg::month_offset(r_f.month[3:0])})
                            + $signed({15'd0, r_f.day}) - tsepoch_pkg::DayBias;
                n_state   = tsepoch_pkg::CV_DAYS;
            end
            tsepoch_pkg::CV_DAYS: begin
                mac_a   = $signed({46'd0, y_adj});
                mac_k   = tsepoch_pkg::KYear;
                mac_c   = 60'(r_base) - $signed({53'd0, r_q100})
                          + $signed({55'd0, r_q100[6:2]});
                n_acc   = mac_p;
                n_state = tsepoch_pkg::CV_HOUR;
            end
            tsepoch_pkg::CV_HOUR: begin
                mac_k   = tsepoch_pkg::KHours;
                mac_c   = $signed({53'd0, r_f.hour});
                n_acc   = mac_p;
                n_state = tsepoch_pkg::CV_MIN;
            end
            tsepoch_pkg::CV_MIN: begin
                mac_k   = tsepoch_pkg::KSixty;
                mac_c   = $signed({53'd0, r_f.minute});
                n_acc   = mac_p;
                n_state = tsepoch_pkg::CV_SEC;
            end
            tsepoch_pkg::CV_SEC: begin
                mac_k   = tsepoch_pkg::KSixty;
                mac_c   = $signed({53'd0, r_f.second});
                n_acc   = mac_p;
                n_neg1  = (mac_p == -60'sd1);
                n_state = tsepoch_pkg::CV_MS;
            end
            tsepoch_pkg::CV_MS: begin
                mac_k   = tsepoch_pkg::KMilli;
                n_acc   = mac_p;
                n_state = tsepoch_pkg::CV_US;
            end
            tsepoch_pkg::CV_US: begin
                mac_k   = tsepoch_pkg::KMilli;
                mac_c   = $signed({40'd0, r_frac_us});
                n_acc   = mac_p;
                n_state = tsepoch_pkg::CV_DONE;
            end
            tsepoch_pkg::CV_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_pok       = r_ok && !r_neg1;
                    n_epoch     = (r_ok && !r_neg1) ? r_acc[58:0] : '0;
                    n_state     = tsepoch_pkg::CV_IDLE;
                end
            end
            default: begin
                n_state = tsepoch_pkg::CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsepoch_pkg::CV_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tsepoch_pkg::CV_IDLE && i_start) begin
            r_f <= i_fields;
        end
        r_acc     <= n_acc;
        r_fcnt    <= n_fcnt;
        r_frac_us <= n_frac_us;
        r_q100    <= n_q100;
        r_base    <= n_base;
        r_neg1    <= n_neg1;
        r_ok      <= n_ok;
        r_epoch   <= n_epoch;
        r_pok     <= n_pok;
    end

    assign o_busy         = (r_state != tsepoch_pkg::CV_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_epoch_micros = r_epoch;
    assign o_parsed_ok    = r_pok;

endmodule

// ----- rtl/core/timestamp_text_to_epoch_micros_top.sv -----
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_micros_top
// UTC timestamp text, one character per item, to signed epoch microseconds.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_text_char, i_last_char
//   out      output     o_out_valid / i_out_stall o_epoch_micros, o_parsed_ok
//
// Character items are taken while the input does not stall. After the last
// character the input stalls while the shared multiply-add unit runs the
// conversion sequence; the result then sits in the output register.
// Conversion end waits while an earlier result is stalled.
// Reset is synchronous, active low, and clears position, fields and sequencer.
// ----------------------------------------------------------------------------
module timestamp_text_to_epoch_micros_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_text_char,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [58:0] o_epoch_micros,
    output logic               o_parsed_ok
);

    tsepoch_pkg::t_fields fields;
    logic                 busy;
    logic                 take;

    assign take       = i_in_valid && !busy;
    assign o_in_stall = busy;

    tsepoch_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_text_char (i_text_char),
        .i_last_char (i_last_char),
        .o_fields    (fields)
    );

    tsepoch_conv u_conv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (take && i_last_char),
        .i_fields       (fields),
        .o_busy         (busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_epoch_micros (o_epoch_micros),
        .o_parsed_ok    (o_parsed_ok)
    );

endmodule

// ----- rtl/core/tsepoch_chk.sv -----
// ----------------------------------------------------------------------------
// tsepoch_chk
// Port-level checks for the timestamp text to epoch block.
// ----------------------------------------------------------------------------
module tsepoch_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_last_char,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [58:0] o_epoch_micros,
    input logic               o_parsed_ok
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_epoch_micros)
                                       && $stable(o_parsed_ok))
        else $error("out item changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_parsed_ok |-> o_epoch_micros == 59'sd0)
        else $error("failed parse gave nonzero value");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_char |=> o_in_stall)
        else $error("last item did not start conversion");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && !o_in_stall))
        else $error("result appeared right after an input item");

endmodule

bind timestamp_text_to_epoch_micros_top tsepoch_chk u_tsepoch_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_char    (i_last_char),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_epoch_micros (o_epoch_micros),
    .o_parsed_ok    (o_parsed_ok)
);

// ----- tb/sv/tb_timestamp_text_to_epoch_micros_top.sv -----
// ----------------------------------------------------------------------------
// tb_timestamp_text_to_epoch_micros_top
// Self-checking bench for the timestamp text to epoch microseconds block.
//
// Timestamps go in one character per item. A table of directed timestamps
// (epoch, calendar extremes, short text, bad separators and digits, fields
// out of range, the second before the epoch, fraction forms) comes first.
// Random timestamps follow: mostly well-formed with random fields, plus
// fields out of range, broken layouts and raw byte noise. A bench-side
// parser and calendar conversion predicts random results, typed values
// give most directed ones; each is checked field by field in order. The
// sender idles in bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_timestamp_text_to_epoch_micros_top;

    typedef struct packed {
        logic signed [58:0] micros;
        logic               ok;
    } t_epoch_result;

    localparam int NumDirected  = 25;
    localparam int RandomChars  = 1330;
    localparam int DrainLimit   = 20000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_text_char = 8'h00;
    logic               i_last_char = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [58:0] o_epoch_micros;
    logic               o_parsed_ok;

    timestamp_text_to_epoch_micros_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_char    (i_text_char),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_epoch_micros (o_epoch_micros),
        .o_parsed_ok    (o_parsed_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state of the bench copy
    logic [4:0]  char_pos;
    logic [13:0] year_acc;
    logic [6:0]  month_acc;
    logic [6:0]  day_acc;
    logic [6:0]  hour_acc;
    logic [6:0]  minute_acc;
    logic [6:0]  second_acc;
    logic [19:0] frac_acc;
    logic [2:0]  frac_cnt;
    bit          layout_bad;
    bit          frac_closed;

    t_epoch_result epoch_q[$];
    logic [7:0]    stamp_chars[$];
    int            error_count = 0;
    int            burst_left  = 0;
    t_epoch_result oldest;

    string dir_text [NumDirected] = '{
        "1970-01-01 00:00:00",
        "1970-01-01T00:00:01",
        "1969-12-31 23:59:59",
        "0000-01-01 00:00:00",
        "9999-12-31 23:59:61.999999",
        "1970-01-01 00:00:0",
        "X",
        "1970/01-01 00:00:00",
        "19a0-01-01 00:00:00",
        "1970-00-01 00:00:00",
        "1970-13-01 00:00:00",
        "1970-01-00 00:00:00",
        "1970-01-32 00:00:00",
        "1970-01-01 24:00:00",
        "1970-01-01 00:60:00",
        "1970-01-01 00:00:62",
        "1970-01-01 00:00:00.5",
        "1970-01-01 00:00:00.1234567xyz",
        "1970-01-01 00:00:00.",
        "1970-01-01 00:00:00x123",
        "1969-12-31 23:59:59.5",
        "1970-01-01_00:00:00",
        "2000-02-30 12:34:56.789",
        "2024-12-31T23:59:60.000001 trailing text past the end",
        "1999-02-29 00:00:00"
    };
    bit dir_typed [NumDirected] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0
    };
    longint dir_micros [NumDirected] = '{
        0, 1000000, 0, -64'd62167219200000000, 64'd253402300801999999,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 500000, 123456, 0, 0, 0, 0, 0, 0, 0
    };
    bit dir_ok [NumDirected] = '{
        1, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0, 0
    };

    function automatic void clear_parser();
        char_pos    = '0;
        year_acc    = '0;
        month_acc   = '0;
        day_acc     = '0;
        hour_acc    = '0;
        minute_acc  = '0;
        second_acc  = '0;
        frac_acc    = '0;
        frac_cnt    = '0;
        layout_bad  = 1'b0;
        frac_closed = 1'b0;
    endfunction

    function automatic void add_char(input logic [7:0] c);
        stamp_chars.insert(stamp_chars.size(), c);
    endfunction

    function automatic longint days_since_epoch(input longint y, input int m);
        longint cyc;
        longint yc;
        longint dc;
        int     mshift;
        if (m <= 2) y = y - 1;
        y      = y + 400;
        cyc    = y / 400;
        yc     = y - cyc * 400;
        mshift = (m + 9) % 12;
        dc     = yc * 365 + yc / 4 - yc / 100 + (153 * mshift + 2) / 5;
        return cyc * 146097 + dc - 719468 - 146097;
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input logic last,
                                      output t_epoch_result r);
        bit         dig;
        logic [6:0] d;
        logic [4:0] at;
        bit         good;
        longint     secs;
        longint     scale;
        longint     res;
        int         k;
        dig = (c >= "0") && (c <= "9");
        d   = dig ? 7'(c - "0") : 7'd0;
        at  = char_pos;
        r   = '0;
        res = 0;
        if (at <= tsepoch_pkg::PosSecEnd) begin
            if (at == tsepoch_pkg::PosDash1 || at == tsepoch_pkg::PosDash2) begin
                if (c != "-") layout_bad = 1'b1;
            end else if (at == tsepoch_pkg::PosSep) begin
                if (c != " " && c != "T") layout_bad = 1'b1;
            end else if (at == tsepoch_pkg::PosColon1 || at == tsepoch_pkg::PosColon2) begin
                if (c != ":") layout_bad = 1'b1;
            end else if (!dig) begin
                layout_bad = 1'b1;
            end else if (at <= tsepoch_pkg::PosYearEnd) begin
                year_acc = year_acc * 14'd10 + 14'(d);
            end else if (at <= tsepoch_pkg::PosMonthEnd) begin
                month_acc = month_acc * 7'd10 + d;
            end else if (at <= tsepoch_pkg::PosDayEnd) begin
                day_acc = day_acc * 7'd10 + d;
            end else if (at <= tsepoch_pkg::PosHourEnd) begin
                hour_acc = hour_acc * 7'd10 + d;
            end else if (at <= tsepoch_pkg::PosMinEnd) begin
                minute_acc = minute_acc * 7'd10 + d;
            end else begin
                second_acc = second_acc * 7'd10 + d;
            end
        end else if (at == tsepoch_pkg::PosFrac) begin
            if (c != ".") frac_closed = 1'b1;
        end else if (at <= tsepoch_pkg::PosFracEnd) begin
            if (!frac_closed && dig && frac_cnt < tsepoch_pkg::FracDigits) begin
                frac_acc = frac_acc * 20'd10 + 20'(d);
                frac_cnt = frac_cnt + 3'd1;
            end else begin
                frac_closed = 1'b1;
            end
        end
        if (char_pos != tsepoch_pkg::PosMax) char_pos = char_pos + 5'd1;
        if (!last) return 1'b0;

        good = (at >= tsepoch_pkg::PosSecEnd) && !layout_bad &&
               month_acc >= 1 && month_acc <= 12 && day_acc >= 1 && day_acc <= 31 &&
               hour_acc <= 23 && minute_acc <= 59 && second_acc <= 61;
        if (good) begin
            secs = (days_since_epoch(longint'(year_acc), int'(month_acc)) +
                    longint'(day_acc) - 1) * 86400 + longint'(hour_acc) * 3600 +
                   longint'(minute_acc) * 60 + longint'(second_acc);
            scale = 1;
            for (k = int'(frac_cnt); k < 6; k++) scale = scale * 10;
            if (secs == -1) good = 1'b0;
            else res = secs * 1000000 + longint'(frac_acc) * scale;
        end
        r.micros = res[58:0];
        r.ok     = good;
        clear_parser();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (epoch_q.size() == 0) begin
                report_mismatch("unexpected result, epoch_micros", longint'(o_epoch_micros), 0);
            end else begin
                oldest = epoch_q.pop_front();
                if (o_epoch_micros !== oldest.micros)
                    report_mismatch("epoch_micros", longint'(o_epoch_micros),
                                    longint'(oldest.micros));
                if (o_parsed_ok !== oldest.ok)
                    report_mismatch("parsed_ok", longint'(o_parsed_ok), longint'(oldest.ok));
            end
        end
    end

    int stall_left = 0;
    int stall_mode = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(3);
            stall_left <= $urandom_range(300, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(2) == 0);
            2: i_out_stall <= ((stall_left % 24) < 12);
            default: i_out_stall <= stall_left[0];
        endcase
    end

    task automatic send_stamp(input bit typed, input t_epoch_result typed_r);
        int            n;
        logic          last;
        t_epoch_result r;
        for (n = 0; n < stamp_chars.size(); n++) begin
            last = (n == stamp_chars.size() - 1);
            i_in_valid  <= 1'b1;
            i_text_char <= stamp_chars[n];
            i_last_char <= last;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            if (parse_char(stamp_chars[n], last, r))
                epoch_q.insert(epoch_q.size(), typed ? typed_r : r);
            @(negedge i_clk);
            if (burst_left == 0 || last) i_in_valid <= 1'b0;
            if (burst_left == 0) begin
                burst_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                      : $urandom_range(12, 1);
                repeat ($urandom_range(8, 1)) @(negedge i_clk);
            end else begin
                burst_left--;
                if (last) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_for_results();
        int n;
        n = 0;
        while (epoch_q.size() != 0 && n < DrainLimit) begin
            @(negedge i_clk);
            n++;
        end
        if (epoch_q.size() != 0)
            report_mismatch("results left pending", epoch_q.size(), 0);
    endtask

    function automatic void put_num(input int v, input int w);
        int k;
        int p;
        p = 1;
        for (k = 1; k < w; k++) p = p * 10;
        for (k = 0; k < w; k++) begin
            add_char(8'((v / p) % 10 + 48));
            p = p / 10;
        end
    endfunction

    task automatic make_random_stamp();
        int         kind;
        int         yr, mo, dy, hr, mi, se;
        int         k;
        int         cut;
        logic [7:0] sep;
        kind = $urandom_range(99);
        yr   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 9999 : 0) : $urandom_range(9999);
        mo   = $urandom_range(12, 1);
        dy   = $urandom_range(31, 1);
        hr   = $urandom_range(23);
        mi   = $urandom_range(59);
        se   = $urandom_range(61);
        sep  = $urandom_range(1) ? "T" : " ";
        if ($urandom_range(24) == 0) begin
            yr = 1969; mo = 12; dy = 31; hr = 23; mi = 59; se = 59;
        end else if ($urandom_range(24) == 0) begin
            yr = 1970; mo = 1; dy = 1; hr = 0; mi = 0; se = 0;
        end
        if (kind >= 60 && kind < 75) begin
            case ($urandom_range(4))
                0: mo = $urandom_range(1) ? 0 : $urandom_range(99, 13);
                1: dy = $urandom_range(1) ? 0 : $urandom_range(99, 32);
                2: hr = $urandom_range(99, 24);
                3: mi = $urandom_range(99, 60);
                default: se = $urandom_range(99, 62);
            endcase
        end
        stamp_chars.delete();
        put_num(yr, 4);
        add_char("-");
        put_num(mo, 2);
        add_char("-");
        put_num(dy, 2);
        add_char(sep);
        put_num(hr, 2);
        add_char(":");
        put_num(mi, 2);
        add_char(":");
        put_num(se, 2);
        if ($urandom_range(1)) begin
            add_char(".");
            for (k = $urandom_range(8); k > 0; k--)
                add_char(8'($urandom_range(57, 48)));
        end
        if ($urandom_range(2) == 0)
            for (k = $urandom_range(10, 1); k > 0; k--)
                add_char(8'($urandom_range(255)));
        if (kind >= 75 && kind < 88) begin
            if ($urandom_range(1)) begin
                cut = $urandom_range(18, 1);
                while (stamp_chars.size() > cut) void'(stamp_chars.pop_back());
            end else begin
                stamp_chars[$urandom_range(18)] = 8'($urandom_range(255));
            end
        end else if (kind >= 88) begin
            stamp_chars.delete();
            for (k = $urandom_range(40, 1); k > 0; k--)
                add_char(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int            row;
        int            k;
        int            chars_sent;
        t_epoch_result typed_r;
        clear_parser();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < NumDirected; row++) begin
            stamp_chars.delete();
            for (k = 0; k < dir_text[row].len(); k++) add_char(dir_text[row][k]);
            typed_r.micros = dir_micros[row][58:0];
            typed_r.ok     = dir_ok[row];
            send_stamp(dir_typed[row], typed_r);
        end
        wait_for_results();

        chars_sent = 0;
        typed_r    = '0;
        while (chars_sent < RandomChars) begin
            make_random_stamp();
            chars_sent += stamp_chars.size();
            send_stamp(1'b0, typed_r);
            if ($urandom_range(14) == 0) wait_for_results();
        end
        i_in_valid <= 1'b0;

        wait_for_results();
        repeat (40) @(negedge i_clk);
        if (epoch_q.size() != 0) report_mismatch("results left pending", epoch_q.size(), 0);
        if (error_count == 0) begin
            $display("timestamp_text_to_epoch_micros_top verification clean");
        end else begin
            $display("timestamp_text_to_epoch_micros_top verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timestamp_text_to_epoch_micros_top verification failed");
        $finish;
    end

endmodule
